@@ rtl/primality_test_u64_assert.svh @@
// Assertion macros shared by the primality test RTL files.
`ifndef PRIMALITY_TEST_U64_ASSERT_SVH
`define PRIMALITY_TEST_U64_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define PT64_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pt64 assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define PT64_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pt64 assertion failed");
`else
`define PT64_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PT64_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/pt64_pkg.sv @@
// Types and constants shared by the primality test modules.
`default_nettype none

package pt64_pkg;

  localparam int WORD_W        = 64;
  localparam int TRIAL_COUNT   = 12;
  localparam int WITNESS_COUNT = 7;
  localparam int PRIME_W       = 6;
  localparam int SHIFT_W       = 6;
  localparam int BASE_IDX_W    = 3;

  localparam logic [PRIME_W-1:0] TRIAL_PRIME [TRIAL_COUNT] = '{
    6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
  };

  localparam logic [WORD_W-1:0] WITNESS_BASE [WITNESS_COUNT] = '{
    64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504, 64'd1795265022
  };

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRIAL,
    S_SMALL,
    S_SPLIT,
    S_BASE,
    S_RED_W,
    S_POW,
    S_PMUL_W,
    S_POW_SQ,
    S_PSQ_W,
    S_CHK,
    S_LOOP,
    S_SQ_W,
    S_NEXT,
    S_DONE
  } pt_state_e;

  typedef enum logic [1:0] {
    MM_IDLE,
    MM_ADD,
    MM_DBL
  } mm_state_e;

  typedef struct packed {
    logic              go;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] product;
  } mm_rsp_t;

endpackage

`default_nettype wire

@@ rtl/pt64_modmul.sv @@
// Add-and-double modular multiplier built around one 64-bit modular adder.
`default_nettype none
`include "primality_test_u64_assert.svh"

module pt64_modmul
  import pt64_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [WORD_W-1:0] n_i,
  input  wire mm_req_t           req_i,
  output mm_rsp_t                rsp_o
);

  mm_state_e         state_q, state_d;
  logic [WORD_W-1:0] x_q, x_d;
  logic [WORD_W-1:0] y_q, y_d;
  logic [WORD_W-1:0] acc_q, acc_d;

  logic              use_acc;
  logic [WORD_W-1:0] add_p;
  logic [WORD_W:0]   add_sum;
  logic [WORD_W:0]   add_dif;
  logic [WORD_W-1:0] add_res;

  // Shared modular adder: (p + x) mod n for p, x below n.
  assign use_acc = (state_q == MM_ADD) && y_q[0];
  assign add_p   = use_acc ? acc_q : x_q;
  assign add_sum = {1'b0, add_p} + {1'b0, x_q};
  assign add_dif = add_sum - {1'b0, n_i};
  assign add_res = (add_sum >= {1'b0, n_i}) ? add_dif[WORD_W-1:0] : add_sum[WORD_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      MM_IDLE: begin
        if (req_i.go) state_d = MM_ADD;
      end
      MM_ADD: begin
        if (y_q == '0) begin
          state_d = MM_IDLE;
        end else if (y_q[0]) begin
          state_d = MM_DBL;
        end
      end
      MM_DBL: state_d = MM_ADD;
      default: state_d = MM_IDLE;
    endcase
  end

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    acc_d = acc_q;
    case (state_q)
      MM_IDLE: begin
        if (req_i.go) begin
          x_d   = req_i.a;
          y_d   = req_i.b;
          acc_d = '0;
        end
      end
      MM_ADD: begin
        if (y_q != '0) begin
          if (y_q[0]) begin
            acc_d = add_res;
          end else begin
            // no add for a clear bit: double straight away
            x_d = add_res;
            y_d = {1'b0, y_q[WORD_W-1:1]};
          end
        end
      end
      MM_DBL: begin
        x_d = add_res;
        y_d = {1'b0, y_q[WORD_W-1:1]};
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_o.busy    = (state_q != MM_IDLE);
    rsp_o.done    = (state_q == MM_ADD) && (y_q == '0);
    rsp_o.product = acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  `PT64_ASSERT_IMP(a_mm_acc_reduced, clk_i, rst_ni, state_q != MM_IDLE, acc_q < n_i)
  `PT64_ASSERT_IMP(a_mm_x_reduced, clk_i, rst_ni, state_q != MM_IDLE, x_q < n_i)
  `PT64_ASSERT_NXT(a_mm_done_idle, clk_i, rst_ni, rsp_o.done, state_q == MM_IDLE)

endmodule

`default_nettype wire

@@ rtl/primality_test_u64.sv @@
// Top level of the deterministic 64-bit Miller-Rabin primality test.
// A candidate that the twelve-prime trial sweep settles ends there; otherwise the test runs
// up to seven bases (~128 modular products each).
// Each product adds and doubles, bit by bit, on the single 64-bit modular adder.
// Throughput: one candidate at a time; busy stays high until the strobe cycle ends.
// Reset (rst_ni, asynchronous, active low) returns the sequencer to idle and drops any test.
// The result is shown for one cycle on done_o and is_prime_o; the receiver cannot stall.
`default_nettype none
`include "primality_test_u64_assert.svh"

module primality_test_u64
  import pt64_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] candidate_i,
  output logic                   busy,
  output logic                   done_o,
  output logic                   is_prime_o
);

  pt_state_e state_q, state_d;

  // Candidate and its decrement, held for the whole test
  logic [WORD_W-1:0]     n_q, n_d;
  logic [WORD_W-1:0]     nm1_q, nm1_d;

  // n - 1 = d * 2^s
  logic [WORD_W-1:0]     d_q, d_d;
  logic [SHIFT_W-1:0]    s_q, s_d;

  // Exponentiation registers: remaining exponent, running square, running product
  logic [WORD_W-1:0]     e_q, e_d;
  logic [WORD_W-1:0]     xb_q, xb_d;
  logic [WORD_W-1:0]     acc_q, acc_d;
  logic [SHIFT_W-1:0]    k_q, k_d;
  logic [BASE_IDX_W-1:0] base_idx_q, base_idx_d;

  // Trial sweep: one residue lane per small prime, fed one candidate bit per cycle
  logic [SHIFT_W-1:0]    bit_cnt_q, bit_cnt_d;
  logic [PRIME_W-1:0]    res_q [TRIAL_COUNT];
  logic [PRIME_W-1:0]    res_d [TRIAL_COUNT];

  logic                  verdict_q, verdict_d;

  logic                  is_small_prime;
  logic                  any_zero;
  logic                  below_two;
  logic                  last_base;
  logic                  k_below_s;

  mm_req_t               mm_req;
  mm_rsp_t               mm_rsp;

  pt64_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .n_i    (n_q),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  // Decide the small cases once the sweep is over
  always_comb begin
    is_small_prime = 1'b0;
    any_zero       = 1'b0;
    for (int i = 0; i < TRIAL_COUNT; i++) begin
      if (n_q == {{(WORD_W-PRIME_W){1'b0}}, TRIAL_PRIME[i]}) is_small_prime = 1'b1;
      if (res_q[i] == '0) any_zero = 1'b1;
    end
  end

  assign below_two = (n_q[WORD_W-1:1] == '0);
  assign last_base = (base_idx_q == BASE_IDX_W'(WITNESS_COUNT - 1));
  assign k_below_s = (k_q < s_q);

  // Next residue per lane: r = (2r + bit) mod p, one conditional subtract
  always_comb begin
    logic [PRIME_W:0] t;
    for (int i = 0; i < TRIAL_COUNT; i++) begin
      t = {res_q[i], n_q[bit_cnt_q]};
      if (t >= {1'b0, TRIAL_PRIME[i]}) t = t - {1'b0, TRIAL_PRIME[i]};
      res_d[i] = t[PRIME_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_TRIAL;
      end
      S_TRIAL: begin
        if (bit_cnt_q == '0) state_d = S_SMALL;
      end
      S_SMALL: begin
        if (below_two || is_small_prime || any_zero) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (d_q[0]) state_d = S_BASE;
      end
      S_BASE: state_d = S_RED_W;
      S_RED_W: begin
        if (mm_rsp.done) begin
          // a base that the candidate divides is skipped
          state_d = (mm_rsp.product == '0) ? S_NEXT : S_POW;
        end
      end
      S_POW: begin
        if (e_q == '0) begin
          state_d = S_CHK;
        end else if (e_q[0]) begin
          state_d = S_PMUL_W;
        end else begin
          state_d = S_POW_SQ;
        end
      end
      S_PMUL_W: begin
        if (mm_rsp.done) state_d = S_POW_SQ;
      end
      S_POW_SQ: begin
        state_d = (e_q[WORD_W-1:1] != '0) ? S_PSQ_W : S_POW;
      end
      S_PSQ_W: begin
        if (mm_rsp.done) state_d = S_POW;
      end
      S_CHK: begin
        if ((acc_q == {{(WORD_W-1){1'b0}}, 1'b1}) || (acc_q == nm1_q)) begin
          state_d = S_NEXT;
        end else begin
          state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        state_d = k_below_s ? S_SQ_W : S_DONE;
      end
      S_SQ_W: begin
        if (mm_rsp.done) state_d = (mm_rsp.product == nm1_q) ? S_NEXT : S_LOOP;
      end
      S_NEXT: begin
        state_d = last_base ? S_DONE : S_BASE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath register updates
  always_comb begin
    n_d        = n_q;
    nm1_d      = nm1_q;
    d_d        = d_q;
    s_d        = s_q;
    e_d        = e_q;
    xb_d       = xb_q;
    acc_d      = acc_q;
    k_d        = k_q;
    base_idx_d = base_idx_q;
    bit_cnt_d  = bit_cnt_q;
    verdict_d  = verdict_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          n_d       = candidate_i;
          bit_cnt_d = '1;
        end
      end
      S_TRIAL: begin
        bit_cnt_d = bit_cnt_q - SHIFT_W'(1);
      end
      S_SMALL: begin
        // below two or a small divisor gives composite; a small prime itself gives prime
        verdict_d  = is_small_prime;
        nm1_d      = n_q - WORD_W'(1);
        d_d        = n_q - WORD_W'(1);
        s_d        = '0;
        base_idx_d = '0;
      end
      S_SPLIT: begin
        if (!d_q[0]) begin
          d_d = {1'b0, d_q[WORD_W-1:1]};
          s_d = s_q + SHIFT_W'(1);
        end
      end
      S_RED_W: begin
        if (mm_rsp.done) begin
          xb_d  = mm_rsp.product;
          acc_d = WORD_W'(1);
          e_d   = d_q;
        end
      end
      S_PMUL_W: begin
        if (mm_rsp.done) acc_d = mm_rsp.product;
      end
      S_POW_SQ: begin
        e_d = {1'b0, e_q[WORD_W-1:1]};
      end
      S_PSQ_W: begin
        if (mm_rsp.done) xb_d = mm_rsp.product;
      end
      S_CHK: begin
        k_d = SHIFT_W'(1);
      end
      S_LOOP: begin
        if (!k_below_s) verdict_d = 1'b0;
      end
      S_SQ_W: begin
        if (mm_rsp.done) begin
          acc_d = mm_rsp.product;
          k_d   = k_q + SHIFT_W'(1);
        end
      end
      S_NEXT: begin
        if (last_base) begin
          verdict_d = 1'b1;
        end else begin
          base_idx_d = base_idx_q + BASE_IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Outputs and multiplier requests
  always_comb begin
    busy       = (state_q != S_IDLE);
    done_o     = (state_q == S_DONE);
    is_prime_o = verdict_q;
    mm_req.go  = 1'b0;
    mm_req.a   = acc_q;
    mm_req.b   = xb_q;
    case (state_q)
      S_BASE: begin
        // reduce the base: 1 * base mod n
        mm_req.go = 1'b1;
        mm_req.a  = WORD_W'(1);
        mm_req.b  = WITNESS_BASE[base_idx_q];
      end
      S_POW: begin
        mm_req.go = (e_q != '0) && e_q[0];
        mm_req.a  = acc_q;
        mm_req.b  = xb_q;
      end
      S_POW_SQ: begin
        mm_req.go = (e_q[WORD_W-1:1] != '0);
        mm_req.a  = xb_q;
        mm_req.b  = xb_q;
      end
      S_LOOP: begin
        mm_req.go = k_below_s;
        mm_req.a  = acc_q;
        mm_req.b  = acc_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      verdict_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      verdict_q <= verdict_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    nm1_q      <= nm1_d;
    d_q        <= d_d;
    s_q        <= s_d;
    e_q        <= e_d;
    xb_q       <= xb_d;
    acc_q      <= acc_d;
    k_q        <= k_d;
    base_idx_q <= base_idx_d;
    bit_cnt_q  <= bit_cnt_d;
    if (state_q == S_IDLE) begin
      for (int i = 0; i < TRIAL_COUNT; i++) res_q[i] <= '0;
    end else if (state_q == S_TRIAL) begin
      for (int i = 0; i < TRIAL_COUNT; i++) res_q[i] <= res_d[i];
    end
  end

  `PT64_ASSERT_NXT(a_done_to_idle, clk_i, rst_ni, done_o, !busy)
  `PT64_ASSERT_IMP(a_req_when_free, clk_i, rst_ni, mm_req.go, !mm_rsp.busy)
  `PT64_ASSERT_IMP(a_done_in_wait, clk_i, rst_ni, mm_rsp.done, (state_q == S_RED_W) || (state_q == S_PMUL_W) || (state_q == S_PSQ_W) || (state_q == S_SQ_W))
  `PT64_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the 64-bit deterministic primality tester.
`timescale 1ns / 1ps

module tb_top;
  import pt64_pkg::WORD_W;

  // Longest legal item is a large prime; allow a wide margin.
  localparam int unsigned QUIET_LIMIT   = 600_000;
  // Cycles to watch for a stray strobe once the last verdict has arrived.
  localparam int unsigned SETTLE_CYCLES = 1_000;
  localparam int unsigned RANDOM_ITEMS  = 100;
  localparam int unsigned MAX_GAP       = 18;

  localparam logic [WORD_W-1:0] SIEVE_PRIMES [12] = '{
    64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37
  };
  localparam logic [WORD_W-1:0] MR_BASES [7] = '{
    64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504, 64'd1795265022
  };

  typedef struct {
    logic [WORD_W-1:0] value;
    int unsigned       gap;          // idle cycles before the candidate is offered
    bit                drain_first;  // hold back until every verdict has come in
  } candidate_item_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic [WORD_W-1:0] candidate_i;
  logic              busy;
  logic              done_o;
  logic              is_prime_o;

  candidate_item_t   candidate_backlog [$];
  bit                primality_due [$];
  bit                cand_taken;
  bit                armed;
  int unsigned       wait_left;
  int unsigned       quiet_cycles;
  int unsigned       mismatches;

  primality_test_u64 i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .candidate_i (candidate_i),
    .busy        (busy),
    .done_o      (done_o),
    .is_prime_o  (is_prime_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Primality predictor. Modular products go through a 128-bit intermediate,
  // which gives the same residues as the block's add-and-double datapath.
  // ---------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] mulmod_u64(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                                   logic [WORD_W-1:0] m);
    logic [2*WORD_W-1:0] wide;
    wide = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
    wide = wide % {{WORD_W{1'b0}}, m};
    return wide[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] powmod_u64(logic [WORD_W-1:0] b, logic [WORD_W-1:0] e,
                                                   logic [WORD_W-1:0] m);
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] sq;
    acc = 64'd1 % m;
    sq  = b % m;
    while (e != 0) begin
      if (e[0]) acc = mulmod_u64(acc, sq, m);
      e = e >> 1;
      sq = mulmod_u64(sq, sq, m);
    end
    return acc;
  endfunction

  // True when the base is a witness to compositeness of odd n, n - 1 = d * 2^s.
  function automatic bit witness_rejects(logic [WORD_W-1:0] base, logic [WORD_W-1:0] n,
                                         logic [WORD_W-1:0] d, int unsigned s);
    logic [WORD_W-1:0] x;
    // A base that n divides carries no information: skip it.
    if (base % n == 0) return 1'b0;
    x = powmod_u64(base, d, n);
    if (x == 1 || x == n - 1) return 1'b0;
    for (int unsigned k = 1; k < s; k++) begin
      x = mulmod_u64(x, x, n);
      if (x == n - 1) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit lacks_small_factor(logic [WORD_W-1:0] n);
    foreach (SIEVE_PRIMES[i]) begin
      if (n % SIEVE_PRIMES[i] == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit expected_primality(logic [WORD_W-1:0] n);
    logic [WORD_W-1:0] d;
    int unsigned       s;
    if (n < 2) return 1'b0;
    foreach (SIEVE_PRIMES[i]) begin
      if (n == SIEVE_PRIMES[i]) return 1'b1;
    end
    if (!lacks_small_factor(n)) return 1'b0;
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    foreach (MR_BASES[i]) begin
      if (witness_rejects(MR_BASES[i], n, d, s)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] random_word(int unsigned bits);
    logic [WORD_W-1:0] v;
    v = {$urandom, $urandom};
    if (bits < WORD_W) v = v & ((64'd1 << bits) - 1);
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] random_prime(int unsigned bits);
    logic [WORD_W-1:0] v;
    do v = random_word(bits) | 64'd1; while (!expected_primality(v));
    return v;
  endfunction

  task automatic queue_candidate(logic [WORD_W-1:0] value, int unsigned gap, bit drain_first);
    candidate_item_t item;
    item.value       = value;
    item.gap         = gap;
    item.drain_first = drain_first;
    candidate_backlog.push_back(item);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer candidates at the falling edge. Start stays high until the
  // transfer, then either drops or carries the next candidate straight on.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic next_start;
    if (rst_ni && (!start || cand_taken)) begin
      next_start = 1'b0;
      if (!armed && candidate_backlog.size() != 0) begin
        armed     = 1'b1;
        wait_left = candidate_backlog[0].gap;
      end
      if (armed) begin
        if (wait_left != 0) begin
          wait_left--;
        end else if (!(candidate_backlog[0].drain_first && primality_due.size() != 0)) begin
          candidate_i <= candidate_backlog[0].value;
          next_start  = 1'b1;
          void'(candidate_backlog.pop_front());
          armed = 1'b0;
        end
      end
      start <= next_start;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: record each candidate transfer with its predicted verdict, check
  // each strobed verdict against the oldest one, and watch for a hang.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit want;
    if (rst_ni) begin
      if (done_o) begin
        if (primality_due.size() == 0) begin
          $error("is_prime: expected none, got %0b", is_prime_o);
          mismatches++;
        end else begin
          want = primality_due.pop_front();
          if (is_prime_o !== want) begin
            $error("is_prime: expected %0b, got %0b", want, is_prime_o);
            mismatches++;
          end
        end
      end
      if (start && !busy) primality_due.push_back(expected_primality(candidate_i));
      cand_taken <= start && !busy;

      if (done_o || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: fill the backlog, reset once, let the driver empty it, settle.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned       pick;
    int unsigned       bits;
    int unsigned       gap;
    bit                burst;
    logic [WORD_W-1:0] v;

    rst_ni       = 1'b0;
    start        = 1'b0;
    candidate_i  = '0;
    cand_taken   = 1'b0;
    armed        = 1'b0;
    wait_left    = 0;
    quiet_cycles = 0;
    mismatches   = 0;

    // Directed: field extremes, trial-sweep hits, skipped bases and hard composites.
    queue_candidate(64'd0, 0, 1'b0);
    queue_candidate(64'd1, 3, 1'b0);
    queue_candidate(64'd2, 0, 1'b0);
    queue_candidate(64'd3, 0, 1'b0);
    queue_candidate(64'd4, 1, 1'b0);
    queue_candidate(64'd37, 0, 1'b0);
    queue_candidate(64'd38, 0, 1'b0);
    queue_candidate(64'd41, 0, 1'b0);
    queue_candidate(64'd1369, 2, 1'b0);                 // square of the largest sieve prime
    queue_candidate(64'd73, 0, 1'b0);                   // divides two of the bases
    queue_candidate(64'd193, 0, 1'b0);                  // divides one base
    queue_candidate(64'd14089, 0, 1'b0);                // composite that divides a base
    queue_candidate(64'd2047, 0, 1'b0);                 // base-2 strong pseudoprime
    queue_candidate(64'd1152271, 5, 1'b0);              // Carmichael, no small factor
    queue_candidate(64'd3215031751, 0, 1'b0);           // strong pseudoprime to 2, 3, 5, 7
    queue_candidate(64'd341550071728321, 0, 1'b0);
    queue_candidate(64'd4294967311, 0, 1'b0);
    queue_candidate(64'd2305843009213693951, 0, 1'b0);  // Mersenne prime 2^61 - 1
    queue_candidate(64'd9223372036854775783, 0, 1'b0);  // largest prime below 2^63
    queue_candidate(64'd18446743979220271189, 0, 1'b0); // product of two 32-bit primes
    queue_candidate(64'h8000_0000_0000_0000, 0, 1'b0);
    queue_candidate(64'hFFFF_FFFF_FFFF_FFC5, 0, 1'b0);  // largest 64-bit prime
    queue_candidate(64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);

    // Random: mostly candidates that survive the sieve, with bursts and drains.
    burst = 1'b0;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 9) == 0) burst = !burst;
      gap  = burst ? 0 : $urandom_range(0, MAX_GAP);
      bits = ($urandom_range(0, 7) == 0) ? WORD_W : $urandom_range(6, 32);
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1: v = random_word(WORD_W);
        2: v = WORD_W'($urandom_range(0, 200));
        3, 4, 5: begin
          do v = random_word(bits) | 64'd1; while (v < 38 || !lacks_small_factor(v));
        end
        6, 7: v = random_prime((bits > 28) ? 28 : bits);
        8: v = random_prime($urandom_range(8, 20)) * random_prime($urandom_range(8, 20));
        default: begin
          v = 64'd1 << $urandom_range(0, WORD_W - 1);
          v = $urandom_range(0, 1) ? v + 1 : v - 1;
        end
      endcase
      queue_candidate(v, gap, (i % 25) == 0);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (candidate_backlog.size() != 0 || start || primality_due.size() != 0) begin
      @(posedge clk_i);
    end
    // Watch a while longer for any stray strobe.
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
